FILE: rtl/qrs_pkg.sv
// Shared types and constants for the QRS beat detector.
// No dependencies; imported by every module of the block.
package qrs_pkg;

  localparam int FEAT_BITS = 15;
  localparam int WARM_BITS = 16;
  localparam int RUN_BITS  = 8;
  localparam int CFG_BITS  = 16;

  localparam logic [FEAT_BITS-1:0] FEATURE_MAX = {FEAT_BITS{1'b1}};
  localparam logic [WARM_BITS-1:0] WARM_TOP    = {WARM_BITS{1'b1}};

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_WARMUP = 1'b0,
    REG_RUN    = 1'b1
  } cfg_reg_t;

  // Per-word detection status handed from the detector to the output stage
  typedef struct packed {
    logic beat;
    logic warming;
  } det_status_t;

endpackage

FILE: rtl/qrs_feature.sv
// Sample window and Ahlstrom-Tompkins feature for the QRS beat detector.
// Depends on qrs_pkg.
module qrs_feature import qrs_pkg::*; #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic [FEAT_BITS-1:0]          feat
);

  localparam int DW   = SAMPLE_BITS + 1;
  localparam int EW   = SAMPLE_BITS + 2;
  localparam int SUMW = SAMPLE_BITS + 3;
  localparam int CMPW = (SUMW > FEAT_BITS) ? SUMW : FEAT_BITS + 1;

  logic signed [SAMPLE_BITS-1:0] win [4];

  logic signed [DW-1:0] d20, d31, d42;
  logic [DW-1:0]        a20, a31, a42;
  logic signed [EW-1:0] sd;
  logic [EW-1:0]        asd;
  logic [SUMW-1:0]      sum;
  logic [CMPW-1:0]      sum_ext;

  // First differences centered on the three inner taps
  assign d20 = DW'(win[2]) - DW'(win[0]);
  assign d31 = DW'(win[3]) - DW'(win[1]);
  assign d42 = DW'(sample) - DW'(win[2]);
  assign a20 = d20[DW-1] ? DW'(-d20) : DW'(d20);
  assign a31 = d31[DW-1] ? DW'(-d31) : DW'(d31);
  assign a42 = d42[DW-1] ? DW'(-d42) : DW'(d42);

  // Second difference around the middle tap
  assign sd  = EW'(win[0]) - (EW'(win[2]) <<< 1) + EW'(sample);
  assign asd = sd[EW-1] ? EW'(-sd) : EW'(sd);

  assign sum = SUMW'(a20) + (SUMW'(a31) << 1) + SUMW'(a42) + SUMW'(asd);
  assign sum_ext = CMPW'(sum);
  assign feat = (sum_ext > CMPW'(FEATURE_MAX)) ? FEATURE_MAX : FEAT_BITS'(sum_ext);

  // Shift the window by one tap per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) win[i] <= '0;
    end else if (step) begin
      for (int i = 0; i < 3; i++) win[i] <= win[i+1];
      win[3] <= sample;
    end
  end

endmodule

FILE: rtl/qrs_detect.sv
// Running maximum, warm-up, arming and beat counting for the QRS detector.
// Depends on qrs_pkg; also holds the two configuration registers.
module qrs_detect import qrs_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data,
  input  logic                  step,
  input  logic [FEAT_BITS-1:0]  feat,
  output logic [COUNT_BITS-1:0] beats_next,
  output det_status_t           status
);

  logic [WARM_BITS-1:0]  warmup_samples;
  logic [RUN_BITS-1:0]   run_length;
  logic [FEAT_BITS-1:0]  max_feature, max_feature_next;
  logic [WARM_BITS-1:0]  warmup_count, warmup_count_next;
  logic [RUN_BITS-1:0]   run_count, run_count_next;
  logic                  armed, armed_next;
  logic [COUNT_BITS-1:0] beats;

  logic [FEAT_BITS+2:0]  f5;
  logic [FEAT_BITS+3:0]  f10;
  logic [FEAT_BITS+2:0]  m4;
  logic [RUN_BITS-1:0]   need;
  logic                  warming;

  always_ff @(posedge clk) begin
    if (rst) begin
      warmup_samples <= WARM_BITS'(255);
      run_length     <= RUN_BITS'(5);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WARMUP: warmup_samples <= cfg_data[WARM_BITS-1:0];
        REG_RUN:    run_length     <= cfg_data[RUN_BITS-1:0];
        default:    ;
      endcase
    end
  end

  assign f5   = (FEAT_BITS+3)'(feat) + ((FEAT_BITS+3)'(feat) << 2);
  assign f10  = (FEAT_BITS+4)'(f5) << 1;
  assign need = (run_length == '0) ? RUN_BITS'(1) : run_length;

  always_comb begin
    max_feature_next  = (feat > max_feature) ? feat : max_feature;
    m4                = (FEAT_BITS+3)'(max_feature_next) << 2;
    warming           = warmup_count <= warmup_samples;
    warmup_count_next = warmup_count;
    run_count_next    = run_count;
    armed_next        = armed;
    beats_next        = beats;
    status.beat       = 1'b0;
    status.warming    = warming;
    if (warming) begin
      if (warmup_count != WARM_TOP) warmup_count_next = warmup_count + 1'b1;
    end else begin
      // High threshold arms; low threshold extends the run or disarms
      if (f5 >= m4) armed_next = 1'b1;
      if (f10 >= (FEAT_BITS+4)'(max_feature_next) && armed_next) begin
        run_count_next = run_count + 1'b1;
      end else begin
        run_count_next = '0;
        armed_next     = 1'b0;
      end
      if (run_count_next == need) begin
        beats_next     = beats + 1'b1;
        run_count_next = '0;
        armed_next     = 1'b0;
        status.beat    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_feature  <= '0;
      warmup_count <= '0;
      run_count    <= '0;
      armed        <= 1'b0;
      beats        <= '0;
    end else if (step) begin
      max_feature  <= max_feature_next;
      warmup_count <= warmup_count_next;
      run_count    <= run_count_next;
      armed        <= armed_next;
      beats        <= beats_next;
    end
  end

endmodule

FILE: rtl/qrs_beat_detector_core.sv
// Top level of the QRS beat detector: input register, feature and detector
// stage, output register. Depends on qrs_pkg, qrs_feature and qrs_detect.
//
// One ECG sample word in, one result word out, in order. The block takes a
// new word every clock cycle as long as the output side keeps up; each
// word waits in the input register and its result in the output register.
// The rate is set by the step between the input register and the output
// register, where the feature sum, the threshold compares and the beat
// state update all complete for one word. The output register holds a
// finished word while the input register takes the next one, so a stall
// on the output backs up one word deep before in_ready drops. Warm-up
// tracks only the running maximum for warmup_samples + 1 words after
// reset; afterwards a word reaching 0.8 of the maximum arms the detector
// and run_length consecutive words at or above 0.1 of it count one beat.
// Configuration writes take effect at once and belong in idle periods.
module qrs_beat_detector_core import qrs_pkg::*; #(
  parameter int SAMPLE_BITS = 12,
  parameter int COUNT_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [0:0]                    cfg_index,
  input  logic [CFG_BITS-1:0]           cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [FEAT_BITS-1:0]          feature,
  output logic                          beat,
  output logic [COUNT_BITS-1:0]         beat_count,
  output logic                          warming_up
);

  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic                          advance;
  logic                          step;
  logic [FEAT_BITS-1:0]          feat;
  logic [COUNT_BITS-1:0]         beats_next;
  det_status_t                   status;

  // Advance when the output register is empty or being drained
  assign advance  = !out_valid || out_ready;
  assign step     = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_sample <= sample;
  end

  qrs_feature #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_feature (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .sample (s1_sample),
    .feat   (feat)
  );

  qrs_detect #(
    .COUNT_BITS(COUNT_BITS)
  ) u_detect (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .step       (step),
    .feat       (feat),
    .beats_next (beats_next),
    .status     (status)
  );

  // Output register: hold the word until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      feature    <= feat;
      beat       <= status.beat;
      beat_count <= beats_next;
      warming_up <= status.warming;
    end
  end

endmodule

FILE: rtl/qrs_checker.sv
// Port-level checks for the QRS beat detector core, bound to the top level.
// Depends on qrs_pkg and qrs_beat_detector_core.
module qrs_checker import qrs_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  beat,
  input logic                  warming_up,
  input logic [COUNT_BITS-1:0] beat_count
);

  // Reset empties the output register
  a_reset_flush: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid after reset");

  // An empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output register empty");

  // No beat is reported during warm-up
  a_no_beat_warmup: assert property (@(posedge clk) disable iff (rst)
    (out_valid && beat) |-> !warming_up)
    else $error("beat reported during warm-up");

  // Stalled result word holds
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(beat_count) && $stable(beat)))
    else $error("stalled result word changed");

endmodule

bind qrs_beat_detector_core qrs_checker #(
  .COUNT_BITS(COUNT_BITS)
) u_qrs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .beat       (beat),
  .warming_up (warming_up),
  .beat_count (beat_count)
);
